// ===== hw/rtl/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// chm_pkg
// Shared constants and types for the chained hash map: table sizes, entry
// and bucket-head layouts, and result status codes.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int HASH_BITS    = 12;
    localparam int ENTRY_COUNT  = 4096;

    localparam int BUCKET_COUNT = 1 << HASH_BITS;
    localparam int IDX_W        = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int USED_W       = $clog2(ENTRY_COUNT + 1);

    localparam int KEY_W        = 64;
    localparam int VAL_W        = 32;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [HASH_BITS-1:0] bucket_t;

    // bucket head: valid bit plus index of the first entry in the chain
    typedef struct packed {
        logic valid;
        idx_t idx;
    } head_t;

    // one chain entry: key, value handle and link to the next entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             link_valid;
        idx_t             link;
    } entry_t;

    typedef enum logic [1:0] {
        ST_LOOKUP   = 2'd0,
        ST_UPDATED  = 2'd1,
        ST_INSERTED = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

endpackage

// ===== hw/rtl/chained_hash_map_insert_lookup.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map_insert_lookup
// Chained hash map from a 64-bit key to a 32-bit value handle, with lookup
// and register (insert or update) operations.
// ----------------------------------------------------------------------------
// One item is handled at a time. After accept, the bucket head is read, then
// one chain entry is read per cycle until the key matches or the chain ends,
// then the result beat is loaded into the output register once the output is
// free; the entry memory has a single read port. The next item is taken while
// the previous result still waits on the output. After reset the bucket-head
// memory is cleared one bucket per cycle, so no item is accepted until all
// 4096 buckets (2**HASH_BITS) are cleared. Entries are handed out in order
// and never freed; a register of a new key once all entries are in use
// reports table full and stores nothing.
module chained_hash_map_insert_lookup
    import chm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             kind,
    input  logic [KEY_W-1:0] package_id,
    input  logic [VAL_W-1:0] file_ref,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             found,
    output logic [VAL_W-1:0] value_out,
    output logic [1:0]       status
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_RESP
    } state_t;

    state_t             state_reg;
    bucket_t            clr_reg;
    logic [USED_W-1:0]  used_reg;
    logic               kind_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   val_reg;
    head_t              head_reg;
    idx_t               cur_reg;
    logic               res_found_reg;
    logic [VAL_W-1:0]   res_value_reg;
    status_t            res_status_reg;
    logic               out_valid_reg;
    logic               found_reg;
    logic [VAL_W-1:0]   value_reg;
    status_t            status_reg;

    // memories
    head_t  head_mem  [BUCKET_COUNT];
    entry_t entry_mem [ENTRY_COUNT];
    head_t  head_rdata_reg;
    entry_t entry_rdata_reg;

    bucket_t head_raddr;
    logic    head_we;
    bucket_t head_waddr;
    head_t   head_wdata;
    idx_t    entry_raddr;
    logic    entry_we;
    idx_t    entry_waddr;
    entry_t  entry_wdata;

    logic    accept;
    logic    full;
    logic    match;
    logic    finish;
    logic    hit;
    logic    insert;
    logic    update;
    head_t   head_cur;
    status_t res_status;

    assign accept = in_valid && in_ready;
    assign full   = (used_reg == USED_W'(ENTRY_COUNT));
    assign match  = (state_reg == S_WALK) && (entry_rdata_reg.key == key_reg);

    // chain done: empty bucket, key match, or end of chain
    assign finish = ((state_reg == S_HEAD) && !head_rdata_reg.valid)
                 || match
                 || ((state_reg == S_WALK) && !entry_rdata_reg.link_valid);
    assign hit    = match;
    assign update = hit && kind_reg;
    assign insert = finish && !hit && kind_reg && !full;

    // head of the bucket as it stood when the item arrived
    assign head_cur = (state_reg == S_HEAD) ? head_rdata_reg : head_reg;

    always_comb
    begin
        if (!kind_reg)
            res_status = ST_LOOKUP;
        else if (hit)
            res_status = ST_UPDATED;
        else if (full)
            res_status = ST_FULL;
        else
            res_status = ST_INSERTED;
    end

    always_comb
    begin
        head_raddr = package_id[HASH_BITS-1:0];
        head_we    = 1'b0;
        head_waddr = key_reg[HASH_BITS-1:0];
        head_wdata = '{valid: 1'b1, idx: used_reg[IDX_W-1:0]};
        if (state_reg == S_CLEAR)
        begin
            head_we    = 1'b1;
            head_waddr = clr_reg;
            head_wdata = '0;
        end
        else if (insert)
        begin
            head_we = 1'b1;
        end
    end

    always_comb
    begin
        entry_raddr = (state_reg == S_HEAD) ? head_rdata_reg.idx : entry_rdata_reg.link;
        entry_we    = update || insert;
        if (update)
        begin
            entry_waddr = cur_reg;
            entry_wdata = '{key:        entry_rdata_reg.key,
                            value:      val_reg,
                            link_valid: entry_rdata_reg.link_valid,
                            link:       entry_rdata_reg.link};
        end
        else
        begin
            entry_waddr = used_reg[IDX_W-1:0];
            entry_wdata = '{key:        key_reg,
                            value:      val_reg,
                            link_valid: head_cur.valid,
                            link:       head_cur.idx};
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        head_rdata_reg <= head_mem[head_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
            entry_mem[entry_waddr] <= entry_wdata;
        entry_rdata_reg <= entry_mem[entry_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // S_RESP drives the output register itself
            if (out_valid_reg && out_ready && state_reg != S_RESP)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == bucket_t'(BUCKET_COUNT - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg  <= kind;
                        key_reg   <= package_id;
                        val_reg   <= file_ref;
                        state_reg <= S_HEAD;
                    end
                end
                S_HEAD, S_WALK:
                begin
                    if (state_reg == S_HEAD)
                        head_reg <= head_rdata_reg;
                    if (finish)
                    begin
                        res_found_reg  <= hit;
                        res_value_reg  <= (hit && !kind_reg) ? entry_rdata_reg.value : '0;
                        res_status_reg <= res_status;
                        if (insert)
                            used_reg <= used_reg + 1'b1;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        cur_reg   <= entry_raddr;
                        state_reg <= S_WALK;
                    end
                end
                S_RESP:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        found_reg     <= res_found_reg;
                        value_reg     <= res_value_reg;
                        status_reg    <= res_status_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign value_out = value_reg;
    assign status    = status_reg;

    // fill count never runs past the entry store
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(ENTRY_COUNT))
        else $error("used entry count beyond table size");

    // an insert links a new head and takes exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        insert |=> (used_reg == $past(used_reg) + 1'b1))
        else $error("insert did not advance the fill count");

    // head written outside the clearing pass only together with an entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_we && state_reg != S_CLEAR) |-> entry_we)
        else $error("bucket head written without its entry");

    // a full or inserted result never claims the key was found
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL || status == ST_INSERTED)) |-> !found)
        else $error("found set on a new-key result");

    // table full only reported when all entries are taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && res_status_reg == ST_FULL) |-> full)
        else $error("table full reported with free entries");

endmodule
